[hw/rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned COL_IN_W = 7;
  localparam int unsigned ROW_IN_W = 5;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CELL_W  = ATTR_W + CHAR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd14;

  typedef enum logic [OP_W-1:0] {
    OP_PUT  = 2'd0,
    OP_MOVE = 2'd1,
    OP_READ = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [CHAR_W-1:0]   char_code;
    logic [COL_IN_W-1:0] column;
    logic [ROW_IN_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_index;
    logic [CHAR_W-1:0] read_char;
    logic [ATTR_W-1:0] read_attr;
    logic              scrolled;
  } out_t;

endpackage

[hw/rtl/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/tcw_engine.sv]
// ----------------------------------------------------------------------------
// tcw_engine
// cursor, screen ram sequencing and op execution of the console writer
// ----------------------------------------------------------------------------
module tcw_engine #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tcw_pkg::in_t                in_data_i,
  input  logic [tcw_pkg::ATTR_W-1:0]  attr_i,
  output logic                        res_valid_o,
  input  logic                        res_take_i,
  output tcw_pkg::out_t               res_data_o
);

  localparam int unsigned CELLS  = COLUMNS * ROWS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned COL_W  = $clog2(COLUMNS);
  localparam int unsigned ROW_W  = $clog2(ROWS);
  localparam int unsigned LIN_W  = (ADDR_W > tcw_pkg::IDX_W) ? ADDR_W : tcw_pkg::IDX_W;
  localparam int unsigned LAST_SHIFT = CELLS - COLUMNS;

  tcw_pkg::state_e state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic [tcw_pkg::CHAR_W-1:0] rchar_q, rchar_d;
  logic [tcw_pkg::ATTR_W-1:0] rattr_q, rattr_d;
  logic scrolled_q, scrolled_d;

  logic                       ram_we;
  logic [ADDR_W-1:0]          ram_waddr;
  logic [tcw_pkg::CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]          ram_raddr;
  logic [tcw_pkg::CELL_W-1:0] ram_rdata;

  logic             accept;
  logic [COL_W-1:0] col_clamp;
  logic [ROW_W-1:0] row_clamp;
  logic [LIN_W-1:0] cur_lin;
  logic [LIN_W-1:0] tgt_lin;
  logic             last_col;
  logic             last_row;
  logic             advance;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign accept   = in_valid_i && (state_q == tcw_pkg::ST_IDLE);
  assign in_stall_o = (state_q != tcw_pkg::ST_IDLE);

  // saturate move and read targets
  assign col_clamp = ({1'b0, in_data_i.column} >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1)
                                                               : COL_W'(in_data_i.column);
  assign row_clamp = ({2'b0, in_data_i.row} >= 7'(ROWS)) ? ROW_W'(ROWS - 1)
                                                         : ROW_W'(in_data_i.row);

  assign cur_lin = LIN_W'(row_q) * LIN_W'(COLUMNS) + LIN_W'(col_q);
  assign tgt_lin = LIN_W'(row_clamp) * LIN_W'(COLUMNS) + LIN_W'(col_clamp);

  assign last_col = (col_q == COL_W'(COLUMNS - 1));
  assign last_row = (row_q == ROW_W'(ROWS - 1));
  assign advance  = (in_data_i.char_code == tcw_pkg::NEWLINE_CODE) || last_col;

  always_comb begin
    state_d    = state_q;
    col_d      = col_q;
    row_d      = row_q;
    cnt_d      = cnt_q;
    rchar_d    = rchar_q;
    rattr_d    = rattr_q;
    scrolled_d = scrolled_q;
    ram_we     = 1'b0;
    ram_waddr  = ADDR_W'(cur_lin);
    ram_wdata  = {attr_i, in_data_i.char_code};
    ram_raddr  = ADDR_W'(tgt_lin);
    res_valid_o = 1'b0;

    unique case (state_q)
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = '0;
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (accept) begin
          rchar_d    = '0;
          rattr_d    = '0;
          scrolled_d = 1'b0;
          state_d    = tcw_pkg::ST_DONE;
          case (in_data_i.op)
            tcw_pkg::OP_PUT: begin
              ram_we = (in_data_i.char_code != tcw_pkg::NEWLINE_CODE);
              if (advance) begin
                col_d = '0;
                if (last_row) begin
                  scrolled_d = 1'b1;
                  cnt_d      = '0;
                  state_d    = tcw_pkg::ST_SCROLL;
                end else begin
                  row_d = row_q + ROW_W'(1);
                end
              end else begin
                col_d = col_q + COL_W'(1);
              end
            end
            tcw_pkg::OP_MOVE: begin
              col_d = col_clamp;
              row_d = row_clamp;
            end
            tcw_pkg::OP_READ: begin
              state_d = tcw_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        rchar_d = ram_rdata[tcw_pkg::CHAR_W-1:0];
        rattr_d = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
        state_d = tcw_pkg::ST_DONE;
      end

      tcw_pkg::ST_SCROLL: begin
        // read one row ahead; the registered read data is written one row up in the next cycle
        ram_raddr = cnt_q + ADDR_W'(COLUMNS);
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cnt_q == ADDR_W'(LAST_SHIFT)) begin
          state_d = tcw_pkg::ST_FILL;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      tcw_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = {attr_i, tcw_pkg::SPACE_CODE};
        if (cnt_q == ADDR_W'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::ST_DONE;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end

      tcw_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rchar_q    <= rchar_d;
    rattr_q    <= rattr_d;
    scrolled_q <= scrolled_d;
  end

  assign res_data_o.cursor_index = cur_lin[tcw_pkg::IDX_W-1:0];
  assign res_data_o.read_char    = rchar_q;
  assign res_data_o.read_attr    = rattr_q;
  assign res_data_o.scrolled     = scrolled_q;

endmodule

[hw/rtl/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// text mode console: screen ram, cursor, put / move / read ops
// ----------------------------------------------------------------------------
// sequencing: put, move and unused op go from idle to done, then to the output
//   register; a read passes the read state, a scrolling put the scroll and fill
//   states. Input is taken only in idle, after the last result is handed off, by
//   the sequencer that owns the single screen ram write and read port
// reset: cursor to 0, attribute to 14, then a clearing pass zeroes the screen
//   while input is stalled
// ----------------------------------------------------------------------------
module text_console_writer_unit #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // attribute register write
  input  logic                       attr_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0] attr_wdata_i,
  // input transactions
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  tcw_pkg::in_t               in_data_i,
  // result transactions
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output tcw_pkg::out_t              out_data_o
);

  localparam int unsigned SCROLL_LIN = (ROWS - 1) * COLUMNS;

  // attribute used for puts and for the blank row after a scroll
  logic [tcw_pkg::ATTR_W-1:0] attr_q;

  // result handoff from the engine
  logic          res_valid;
  logic          res_take;
  tcw_pkg::out_t res_data;

  // output register, parts the engine from the downstream stall
  logic          out_valid_q;
  tcw_pkg::out_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ATTR_RESET;
    end else if (attr_we_i) begin
      attr_q <= attr_wdata_i;
    end
  end

  tcw_engine #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .attr_i      (attr_q),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_data_o  (res_data)
  );

  // take a finished result when the slot is empty or drains this cycle
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // a handed-off result always lands in the output register
  a_take_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take |=> out_valid_q)
    else $error("result taken but output register empty");

  // the engine never accepts input while it still holds a result
  a_accept_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res_valid)
    else $error("input accepted with a result pending in the engine");

  // a scroll leaves the cursor at column 0 of the last row
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.scrolled) |->
      (out_data_q.cursor_index == tcw_pkg::IDX_W'(SCROLL_LIN)))
    else $error("scroll reported with wrong cursor position");

endmodule
